>>> rtl/core/mprc_pkg.sv
// Package for the map pixel recolor block: field widths, blend and lift
// constants, register indexes and the arithmetic helpers. No dependencies.
`default_nettype none

package mprc_pkg;

    localparam int unsigned CH_W       = 8;
    localparam int unsigned ROW_W      = 12;
    localparam int unsigned PIX_W      = 16;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned NUM_CH     = 3;
    localparam int unsigned STAGES     = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DETAIL_ENABLE = 1'b0,
        CFG_IMAGE_ROWS    = 1'b1
    } t_cfg_idx;

    localparam logic            RST_DETAIL_ENABLE = 1'b0;
    localparam logic [ROW_W-1:0] RST_IMAGE_ROWS   = 12'd240;

    // Blend weights, x/255 each
    localparam logic [15:0] TINT_ALPHA = 16'd72;
    localparam logic [15:0] TINT_KEEP  = 16'd183;
    localparam logic [15:0] BACK_ALPHA = 16'd118;
    localparam logic [15:0] BACK_KEEP  = 16'd137;
    localparam logic [15:0] ROUND_255  = 16'd127;

    localparam logic [CH_W-1:0] TINT [NUM_CH] = '{8'd10, 8'd49, 8'd66};
    localparam logic [CH_W-1:0] BACK [NUM_CH] = '{8'd6, 8'd16, 8'd23};
    localparam logic [CH_W-1:0] BASE [NUM_CH] = '{8'd30, 8'd48, 8'd56};

    localparam logic [15:0] LUMA_KR = 16'd77;
    localparam logic [15:0] LUMA_KG = 16'd150;
    localparam logic [15:0] LUMA_KB = 16'd29;

    localparam logic [CH_W-1:0] LUMA_MIN   = 8'd70;
    localparam logic [CH_W-1:0] SPREAD_MAX = 8'd64;

    // lift = (luma - 70) * 72 / 185; the divide is a multiply by ceil(2^24/185)
    localparam int unsigned LNUM_W      = 14;
    localparam int unsigned LPROD_W     = 31;
    localparam int unsigned LIFT_W      = 7;
    localparam int unsigned LIFT_SHIFT  = 24;
    localparam logic [LNUM_W-1:0]  LIFT_MUL   = 14'd72;
    localparam logic [LPROD_W-1:0] LIFT_RECIP = 31'd90688;

    function automatic logic [15:0] blend1_num(input logic [CH_W-1:0] v,
                                               input logic [CH_W-1:0] tint);
        return 16'(16'(v) * TINT_KEEP) + 16'(16'(tint) * TINT_ALPHA) + ROUND_255;
    endfunction

    function automatic logic [15:0] blend2_num(input logic [CH_W-1:0] a,
                                               input logic [CH_W-1:0] back);
        return 16'(16'(a) * BACK_ALPHA) + 16'(16'(back) * BACK_KEEP) + ROUND_255;
    endfunction

    // floor(x/255) == ((x+1)*257) >> 16 over the 16-bit range used here
    function automatic logic [CH_W-1:0] div255(input logic [15:0] x);
        logic [24:0] p;
        p = 25'(17'(x) + 17'd1) * 25'd257;
        return p[23:16];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/mprc_in_if.sv
// Input channel of the recolor block: one RGB888 pixel and its row.
// Depends on mprc_pkg.
`default_nettype none

interface mprc_in_if import mprc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [ROW_W-1:0] row;

    modport source (output valid, output red, output green, output blue, output row,
                    input ready);
    modport sink   (input valid, input red, input green, input blue, input row,
                    output ready);
endinterface

`default_nettype wire

>>> rtl/core/mprc_out_if.sv
// Output channel of the recolor block: one packed RGB565 pixel.
// Depends on mprc_pkg.
`default_nettype none

interface mprc_out_if import mprc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel565;

    modport source (output valid, output pixel565, input ready);
    modport sink   (input valid, input pixel565, output ready);
endinterface

`default_nettype wire

>>> rtl/core/map_pixel_recolor_rgb565_core.sv
// Top level of the map pixel recolor block: two-step tint blend, grey-area
// detail lift and RGB565 packing. Depends on mprc_pkg, mprc_in_if, mprc_out_if.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+------------------------------
//  i_pix    | in  | valid/ready       | red, green, blue, row
//  o_pix    | out | valid/ready       | pixel565
//  cfg      | in  | i_cfg_we          | i_cfg_idx, i_cfg_data
//
// Five register stages; one pixel per clock while the output is not stalled.
// Stages: products/spread, first /255 and lift numerator, second blend and
// lift reciprocal multiply, second /255, lift floor and pack.
// Synchronous active-low reset empties the pipeline and loads register defaults.
// A stalled output freezes every stage; nothing is dropped or repeated.
`default_nettype none

module map_pixel_recolor_rgb565_core import mprc_pkg::*; #(
    parameter int unsigned BOTTOM_MARGIN = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    mprc_in_if.sink               i_pix,
    mprc_out_if.source            o_pix
);

    logic                   r_det_en;
    logic [ROW_W-1:0]       r_rows;
    logic [STAGES-1:0]      r_vld;
    logic                   adv;

    // stage 1
    logic [15:0]            r_s1_num [NUM_CH];
    logic [15:0]            r_s1_luma;
    logic [CH_W-1:0]        r_s1_spread;
    logic                   r_s1_area;
    logic [15:0]            n_s1_num [NUM_CH];
    logic [15:0]            n_s1_luma;
    logic [CH_W-1:0]        n_s1_spread;
    logic                   n_s1_area;
    logic [CH_W-1:0]        lo;
    logic [CH_W-1:0]        hi;
    logic [ROW_W:0]         row_end;

    // stage 2
    logic [CH_W-1:0]        r_s2_a [NUM_CH];
    logic [LNUM_W-1:0]      r_s2_lnum;
    logic                   r_s2_lift_en;
    logic [CH_W-1:0]        luma;
    logic [CH_W-1:0]        ldiff;
    logic                   n_s2_lift_en;

    // stage 3
    logic [15:0]            r_s3_num [NUM_CH];
    logic [LPROD_W-1:0]     r_s3_lprod;
    logic                   r_s3_lift_en;

    // stage 4
    logic [CH_W-1:0]        r_s4_ch [NUM_CH];
    logic [LIFT_W-1:0]      r_s4_lift;
    logic                   r_s4_lift_en;

    // stage 5
    logic [PIX_W-1:0]       r_s5_pix;
    logic [CH_W-1:0]        n_s5_ch [NUM_CH];
    logic [CH_W-1:0]        lift_floor [NUM_CH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_det_en <= RST_DETAIL_ENABLE;
            r_rows   <= RST_IMAGE_ROWS;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DETAIL_ENABLE: r_det_en <= i_cfg_data[0];
                CFG_IMAGE_ROWS:    r_rows   <= i_cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv         = !r_vld[STAGES-1] || o_pix.ready;
    assign i_pix.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[STAGES-2:0], i_pix.valid};
        end
    end

    always_comb begin
        n_s1_num[0] = blend1_num(i_pix.red, TINT[0]);
        n_s1_num[1] = blend1_num(i_pix.green, TINT[1]);
        n_s1_num[2] = blend1_num(i_pix.blue, TINT[2]);
        n_s1_luma   = 16'(16'(i_pix.red) * LUMA_KR) + 16'(16'(i_pix.green) * LUMA_KG)
                    + 16'(16'(i_pix.blue) * LUMA_KB);
        lo = (i_pix.red < i_pix.green) ? i_pix.red : i_pix.green;
        hi = (i_pix.red > i_pix.green) ? i_pix.red : i_pix.green;
        if (i_pix.blue < lo) begin
            lo = i_pix.blue;
        end
        if (i_pix.blue > hi) begin
            hi = i_pix.blue;
        end
        n_s1_spread = hi - lo;
        row_end     = (ROW_W+1)'(i_pix.row) + (ROW_W+1)'(BOTTOM_MARGIN);
        n_s1_area   = r_det_en && (row_end < (ROW_W+1)'(r_rows));
    end

    always_comb begin
        luma         = r_s1_luma[15:8];
        ldiff        = luma - LUMA_MIN;
        n_s2_lift_en = r_s1_area && (luma > LUMA_MIN) && (r_s1_spread < SPREAD_MAX);
    end

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            lift_floor[c] = BASE[c] + CH_W'(r_s4_lift);
            n_s5_ch[c]    = (r_s4_lift_en && (r_s4_ch[c] < lift_floor[c])) ?
                            lift_floor[c] : r_s4_ch[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_num     <= n_s1_num;
            r_s1_luma    <= n_s1_luma;
            r_s1_spread  <= n_s1_spread;
            r_s1_area    <= n_s1_area;

            for (int c = 0; c < NUM_CH; c++) begin
                r_s2_a[c]   <= div255(r_s1_num[c]);
                r_s3_num[c] <= blend2_num(r_s2_a[c], BACK[c]);
                r_s4_ch[c]  <= div255(r_s3_num[c]);
            end
            r_s2_lnum    <= LNUM_W'(ldiff) * LIFT_MUL;
            r_s2_lift_en <= n_s2_lift_en;

            r_s3_lprod   <= LPROD_W'(r_s2_lnum) * LIFT_RECIP;
            r_s3_lift_en <= r_s2_lift_en;

            r_s4_lift    <= r_s3_lprod[LIFT_SHIFT+LIFT_W-1:LIFT_SHIFT];
            r_s4_lift_en <= r_s3_lift_en;

            r_s5_pix     <= {n_s5_ch[0][7:3], n_s5_ch[1][7:2], n_s5_ch[2][7:3]};
        end
    end

    assign o_pix.valid    = r_vld[STAGES-1];
    assign o_pix.pixel565 = r_s5_pix;

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && !o_pix.ready) |=> $stable(r_vld))
        else $error("pipeline moved during output stall");

    a_lift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && r_s4_lift_en) |-> (r_s4_lift <= 7'd72))
        else $error("detail lift out of range");

    a_lift_needs_luma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[0] && adv && n_s2_lift_en) |=> (r_s2_lnum <= 14'd13320))
        else $error("lift numerator out of range");

endmodule

`default_nettype wire

>>> sim/tb.sv
// Testbench for map_pixel_recolor_rgb565_core: drives RGB888 pixels with row numbers,
// predicts each RGB565 result in-line and checks it against the output channel.
// Depends on mprc_pkg, mprc_in_if, mprc_out_if and the core RTL.
`default_nettype none

module tb;
    import mprc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MARGIN = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    mprc_in_if  pix_in_bus ();
    mprc_out_if pix_out_bus ();

    map_pixel_recolor_rgb565_core #(
        .BOTTOM_MARGIN(MARGIN)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in_bus),
        .o_pix      (pix_out_bus)
    );

    always #4 i_clk = ~i_clk;

    logic             detail_on;
    logic [ROW_W-1:0] rows_cfg;
    logic [15:0]      pending_565[$];
    logic [15:0]      want_565;
    int               mismatches = 0;
    int               burst_left = 0;

    function automatic int blend_ch(input logic [7:0] v, input int tint, input int back);
        int a;
        a = (int'(v) * 183 + tint * 72 + 127) / 255;
        return (a * 118 + back * 137 + 127) / 255;
    endfunction

    function automatic logic [15:0] recolor_pixel(input logic [7:0] r, g, b,
                                                  input logic [ROW_W-1:0] row);
        int lo, hi, luma, lift, nr, ng, nb;
        lo = (r < g) ? r : g;
        hi = (r > g) ? r : g;
        if (b < lo) lo = b;
        if (b > hi) hi = b;
        luma = (77 * int'(r) + 150 * int'(g) + 29 * int'(b)) >> 8;
        nr = blend_ch(r, 10, 6);
        ng = blend_ch(g, 49, 16);
        nb = blend_ch(b, 66, 23);
        if (detail_on && (int'(row) + MARGIN < int'(rows_cfg)) && luma > 70 && hi - lo < 64)
        begin
            lift = ((luma - 70) * 72) / 185;
            if (nr < 30 + lift) nr = 30 + lift;
            if (ng < 48 + lift) ng = 48 + lift;
            if (nb < 56 + lift) nb = 56 + lift;
        end
        return {nr[7:3], ng[7:2], nb[7:3]};
    endfunction

    function automatic logic [7:0] jitter_ch(input int base, input int span);
        int v;
        v = base + $urandom_range(0, span) - span / 2;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    task automatic flag_mismatch(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        $display("MISMATCH %s: expected %h got %h at %0t", what, want, got, $time);
        mismatches++;
    endtask

    task automatic send_pixel(input logic [7:0] r, g, b, input logic [ROW_W-1:0] row);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                pix_in_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        pix_in_bus.valid <= 1'b1;
        pix_in_bus.red   <= r;
        pix_in_bus.green <= g;
        pix_in_bus.blue  <= b;
        pix_in_bus.row   <= row;
        @(posedge i_clk);
        while (!pix_in_bus.ready) @(posedge i_clk);
        pending_565.push_back(recolor_pixel(r, g, b, row));
    endtask

    task automatic settle_pipeline();
        pix_in_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_565.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        settle_pipeline();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_DETAIL_ENABLE: detail_on = data[0];
            CFG_IMAGE_ROWS:    rows_cfg  = data;
            default: ;
        endcase
    endtask

    task automatic test_reset_defaults();
        send_pixel(8'd0, 8'd0, 8'd0, 12'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 12'd4095);
        send_pixel(8'd255, 8'd0, 8'd0, 12'd1);
        send_pixel(8'd0, 8'd255, 8'd0, 12'd2);
        send_pixel(8'd0, 8'd0, 8'd255, 12'd3);
        // image_rows still at its reset height
        write_reg(CFG_DETAIL_ENABLE, 12'd1);
        send_pixel(8'd128, 8'd128, 8'd128, 12'd199);
        send_pixel(8'd128, 8'd128, 8'd128, 12'd200);
    endtask

    task automatic test_lift_thresholds();
        send_pixel(8'd70, 8'd70, 8'd70, 12'd0);
        send_pixel(8'd71, 8'd71, 8'd71, 12'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 12'd0);
        send_pixel(8'd100, 8'd100, 8'd163, 12'd10);
        send_pixel(8'd100, 8'd100, 8'd164, 12'd10);
        send_pixel(8'd163, 8'd100, 8'd100, 12'd10);
    endtask

    task automatic test_row_window();
        write_reg(CFG_IMAGE_ROWS, 12'd4095);
        send_pixel(8'd128, 8'd128, 8'd128, 12'd4054);
        send_pixel(8'd128, 8'd128, 8'd128, 12'd4055);
        send_pixel(8'd128, 8'd128, 8'd128, 12'd4095);
        write_reg(CFG_IMAGE_ROWS, 12'd0);
        send_pixel(8'd128, 8'd128, 8'd128, 12'd0);
        write_reg(CFG_IMAGE_ROWS, 12'd41);
        send_pixel(8'd128, 8'd128, 8'd128, 12'd0);
        send_pixel(8'd128, 8'd128, 8'd128, 12'd1);
        // only bit 0 of the enable register counts
        write_reg(CFG_DETAIL_ENABLE, 12'hffe);
        send_pixel(8'd128, 8'd128, 8'd128, 12'd0);
    endtask

    task automatic test_random_traffic();
        logic [7:0]       r, g, b;
        logic [ROW_W-1:0] row;
        int               base, span, edge_row;
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_DETAIL_ENABLE, {11'($urandom_range(0, 2047)), (ph != 0)});
            case (ph)
                0, 1:    write_reg(CFG_IMAGE_ROWS, 12'd240);
                2:       write_reg(CFG_IMAGE_ROWS, 12'd4095);
                3:       write_reg(CFG_IMAGE_ROWS, 12'($urandom_range(1, 4095)));
                4:       write_reg(CFG_IMAGE_ROWS, 12'd1);
                default: write_reg(CFG_IMAGE_ROWS, 12'($urandom_range(41, 300)));
            endcase
            for (int n = 0; n < 335; n++) begin
                if (n == 160) settle_pipeline();
                if ($urandom_range(0, 9) < 6) begin
                    base = $urandom_range(0, 255);
                    span = $urandom_range(0, 70);
                    r = jitter_ch(base, span);
                    g = jitter_ch(base, span);
                    b = jitter_ch(base, span);
                end else begin
                    r = 8'($urandom_range(0, 255));
                    g = 8'($urandom_range(0, 255));
                    b = 8'($urandom_range(0, 255));
                end
                case ($urandom_range(0, 3))
                    0: begin
                        edge_row = int'(rows_cfg) - MARGIN + $urandom_range(0, 5) - 3;
                        if (edge_row < 0) edge_row = 0;
                        row = ROW_W'(edge_row);
                    end
                    1:       row = ROW_W'($urandom_range(0, rows_cfg));
                    default: row = ROW_W'($urandom_range(0, 4095));
                endcase
                send_pixel(r, g, b, row);
            end
        end
    endtask

    initial begin
        int hold, mode;
        hold = 0;
        mode = 0;
        pix_out_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold == 0) begin
                mode = $urandom_range(0, 3);
                hold = $urandom_range(20, 200);
            end
            hold = hold - 1;
            case (mode)
                0:       pix_out_bus.ready <= 1'b1;
                1:       pix_out_bus.ready <= 1'($urandom_range(0, 1));
                2:       pix_out_bus.ready <= ($urandom_range(0, 3) == 0);
                default: pix_out_bus.ready <= ~pix_out_bus.ready;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pix_out_bus.valid && pix_out_bus.ready) begin
            if (pending_565.size() == 0) begin
                flag_mismatch("unexpected transaction", 16'h0000, pix_out_bus.pixel565);
            end else begin
                want_565 = pending_565.pop_front();
                if (pix_out_bus.pixel565 !== want_565)
                    flag_mismatch("pixel565", want_565, pix_out_bus.pixel565);
            end
        end
    end

    initial begin
        #2ms;
        $display("map_pixel_recolor_rgb565_core test failed");
        $finish;
    end

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_DETAIL_ENABLE;
        i_cfg_data       <= '0;
        pix_in_bus.valid <= 1'b0;
        pix_in_bus.red   <= '0;
        pix_in_bus.green <= '0;
        pix_in_bus.blue  <= '0;
        pix_in_bus.row   <= '0;
        detail_on = 1'b0;
        rows_cfg  = 12'd240;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_lift_thresholds();
        test_row_window();
        test_random_traffic();

        settle_pipeline();
        repeat (STAGES + 10) @(posedge i_clk);
        if (pending_565.size() != 0)
            flag_mismatch("missing transaction", pending_565[0], 16'h0000);
        if (mismatches == 0)
            $display("map_pixel_recolor_rgb565_core test passed");
        else
            $display("map_pixel_recolor_rgb565_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
